>>> rtl/core/acc_pkg.sv
// Shared types and constants for the box-versus-circle contact unit
package acc_pkg;
    localparam int NORMAL_WIDTH = 25;
    localparam int PEN_WIDTH    = 26;
    localparam int D2_WIDTH     = 64;
    localparam int ROOT_WIDTH   = 32;

    typedef struct packed {
        logic                     hit;
        logic                     in_box;
        logic [NORMAL_WIDTH-1:0]  nx;
        logic [NORMAL_WIDTH-1:0]  ny;
        logic [ROOT_WIDTH-1:0]    radius;
    } acc_meta_t;
endpackage

>>> rtl/core/acc_root_cell.sv
// One stage of the pipelined square root: one result bit per cell
module acc_root_cell
    import acc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vin,
    input  logic [D2_WIDTH-1:0]   rem_in,
    input  logic [ROOT_WIDTH-1:0] root_in,
    input  acc_meta_t             meta_in,
    output logic                  vout,
    output logic [D2_WIDTH-1:0]   rem_out,
    output logic [ROOT_WIDTH-1:0] root_out,
    output acc_meta_t             meta_out
);
    localparam int SH = 2 * (ROOT_WIDTH - 1 - STEP);

    logic [D2_WIDTH-1:0] trial;
    logic                ge;
    logic                v_reg;
    logic [D2_WIDTH-1:0] rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    acc_meta_t           meta_reg;

    assign trial = ({root_in, 2'b01} << SH);
    assign ge    = (rem_in >= trial) && ((trial >> SH) == {root_in, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= ge ? rem_in - trial : rem_in;
        root_reg <= {root_in[ROOT_WIDTH-2:0], ge};
        meta_reg <= meta_in;
    end

    assign vout     = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign meta_out = meta_reg;
endmodule

>>> rtl/core/aabb_circle_contact_unit.sv
// Top level of the box-versus-circle contact unit
// Usage: drive all input ports and pulse start; busy is tied low, so a new
// word is taken every cycle. Each accepted word gives exactly one result
// word on hit, center_inside, normal_x, normal_y and penetration, marked by
// done for one cycle. Two front stages compute the offset, clamp, face push
// and squares, the sum and compare feed the first of a row of 32 square-root
// cells that produce one root bit each, and a final output register forms
// the penetration. Throughput is one word per cycle, set by the root cell
// row. Reset clears all valid flags; words in flight are dropped. The
// receiver cannot stall; results must be taken when done rises.
module aabb_circle_contact_unit
    import acc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] box_pos_x,
    input  logic signed [COORD_WIDTH-1:0] box_pos_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_max_x,
    input  logic signed [COORD_WIDTH-1:0] box_max_y,
    input  logic signed [COORD_WIDTH-1:0] circle_pos_x,
    input  logic signed [COORD_WIDTH-1:0] circle_pos_y,
    input  logic        [COORD_WIDTH-2:0] circle_radius,
    output logic                          done,
    output logic                          hit,
    output logic                          center_inside,
    output logic signed [NORMAL_WIDTH-1:0] normal_x,
    output logic signed [NORMAL_WIDTH-1:0] normal_y,
    output logic signed [PEN_WIDTH-1:0]    penetration
);
    localparam int W = COORD_WIDTH + 2;

    function automatic logic signed [W-1:0] clampf(input logic signed [W-1:0] e,
                                                   input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        begin
            if (v < -e)
                r = -e;
            else if (v > e)
                r = e;
            else
                r = v;
            return r;
        end
    endfunction

    function automatic logic [NORMAL_WIDTH-1:0] satn(input logic signed [W:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] vw;
        begin
            vw = 64'(v);
            hi = 64'(2**(NORMAL_WIDTH-1) - 1);
            lo = -hi - 64'sd1;
            if (vw > hi)
                return hi[NORMAL_WIDTH-1:0];
            else if (vw < lo)
                return lo[NORMAL_WIDTH-1:0];
            return vw[NORMAL_WIDTH-1:0];
        end
    endfunction

    function automatic logic [31:0] mag(input logic signed [W:0] v);
        logic [W:0] a;
        begin
            a = v[W] ? (W+1)'(-v) : v;
            if (64'(a) > 64'h7FFF_FFFF)
                return 32'h7FFF_FFFF;
            return 32'(a);
        end
    endfunction

    assign busy = 1'b0;

    logic signed [W-1:0] nx, ny, ex, ey, clx, cly, clx2, cly2;
    logic                ins;

    always_comb
    begin
        nx  = W'(circle_pos_x) - W'(box_pos_x);
        ny  = W'(circle_pos_y) - W'(box_pos_y);
        ex  = (W'(box_max_x) - W'(box_min_x)) >>> 1;
        ey  = (W'(box_max_y) - W'(box_min_y)) >>> 1;
        clx = clampf(ex, nx);
        cly = clampf(ey, ny);
        ins = (clx == nx) && (cly == ny);
        clx2 = clx;
        cly2 = cly;
        if (ins)
        begin
            if ((nx[W-1] ? -nx : nx) > (ny[W-1] ? -ny : ny))
                clx2 = (clx > 0) ? ex : -ex;
            else
                cly2 = (cly > 0) ? ey : -ey;
        end
    end

    logic                v1_reg;
    logic [31:0]         ax_reg, ay_reg;
    logic                ins1_reg;
    logic [NORMAL_WIDTH-1:0] nx1_reg, ny1_reg;
    logic [ROOT_WIDTH-1:0]   r1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= mag((W+1)'(nx) - (W+1)'(clx2));
        ay_reg   <= mag((W+1)'(ny) - (W+1)'(cly2));
        ins1_reg <= ins;
        nx1_reg  <= ins ? satn(-(W+1)'(nx)) : satn((W+1)'(nx));
        ny1_reg  <= ins ? satn(-(W+1)'(ny)) : satn((W+1)'(ny));
        r1_reg   <= ROOT_WIDTH'(circle_radius);
    end

    logic                v2_reg;
    logic [63:0]         sx_reg, sy_reg, r2_reg;
    acc_meta_t           m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= ax_reg * ax_reg;
        sy_reg <= ay_reg * ay_reg;
        r2_reg <= r1_reg * r1_reg;
        m2_reg <= '{hit: 1'b0, in_box: ins1_reg, nx: nx1_reg, ny: ny1_reg,
                    radius: r1_reg};
    end

    logic [D2_WIDTH-1:0] d2;
    acc_meta_t           m3;
    logic                h;

    always_comb
    begin
        d2 = sx_reg + sy_reg;
        h  = (d2 <= r2_reg) || m2_reg.in_box;
        m3 = m2_reg;
        m3.hit = h;
        if (!h)
        begin
            m3.nx = '0;
            m3.ny = '0;
        end
    end

    logic                  vc   [0:ROOT_WIDTH];
    logic [D2_WIDTH-1:0]   remc [0:ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] rootc[0:ROOT_WIDTH];
    acc_meta_t             metac[0:ROOT_WIDTH];

    assign vc[0]    = v2_reg;
    assign remc[0]  = d2;
    assign rootc[0] = '0;
    assign metac[0] = m3;

    for (genvar i = 0; i < ROOT_WIDTH; i++)
    begin : g_root
        acc_root_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vin      (vc[i]),
            .rem_in   (remc[i]),
            .root_in  (rootc[i]),
            .meta_in  (metac[i]),
            .vout     (vc[i+1]),
            .rem_out  (remc[i+1]),
            .root_out (rootc[i+1]),
            .meta_out (metac[i+1])
        );
    end

    acc_meta_t mf;
    logic signed [ROOT_WIDTH+1:0] pdiff;
    logic signed [ROOT_WIDTH+1:0] phi, plo;
    logic [PEN_WIDTH-1:0] pen;

    always_comb
    begin
        mf    = metac[ROOT_WIDTH];
        pdiff = (ROOT_WIDTH+2)'(mf.radius) - (ROOT_WIDTH+2)'(rootc[ROOT_WIDTH]);
        phi   = (ROOT_WIDTH+2)'(2**(PEN_WIDTH-1) - 1);
        plo   = -phi - (ROOT_WIDTH+2)'(1);
        if (pdiff > phi)
            pen = phi[PEN_WIDTH-1:0];
        else if (pdiff < plo)
            pen = plo[PEN_WIDTH-1:0];
        else
            pen = pdiff[PEN_WIDTH-1:0];
        if (!mf.hit)
            pen = '0;
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vc[ROOT_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        hit           <= mf.hit;
        center_inside <= mf.in_box;
        normal_x      <= mf.nx;
        normal_y      <= mf.ny;
        penetration   <= pen;
    end

    assign done = done_reg;

    a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && center_inside |-> hit) else $error("inside without hit");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> normal_x == '0 && normal_y == '0 && penetration == '0)
        else $error("miss fields not zero");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ##(ROOT_WIDTH + 2) done) else $error("word lost in pipeline");
endmodule

>>> bench/aabb_circle_contact_unit_tb.sv
// Self-checking testbench for the box-versus-circle contact unit
module aabb_circle_contact_unit_tb
    import acc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 24;
    localparam int LATENCY = 35;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        logic                    hit;
        logic                    in_box;
        logic [NORMAL_WIDTH-1:0] nx;
        logic [NORMAL_WIDTH-1:0] ny;
        logic [PEN_WIDTH-1:0]    pen;
    } contact_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] box_pos_x = '0, box_pos_y = '0;
    logic signed [CW-1:0] box_min_x = '0, box_min_y = '0;
    logic signed [CW-1:0] box_max_x = '0, box_max_y = '0;
    logic signed [CW-1:0] circle_pos_x = '0, circle_pos_y = '0;
    logic [CW-2:0] circle_radius = '0;
    logic done, hit, center_inside;
    logic signed [NORMAL_WIDTH-1:0] normal_x, normal_y;
    logic signed [PEN_WIDTH-1:0] penetration;

    contact_t pending_contacts[$];
    int mismatches = 0;
    longint cycles = 0;
    bit quiet_sender = 0;

    aabb_circle_contact_unit #(.COORD_WIDTH(CW)) dut (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sat_to(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint bound(longint lo, longint hi, longint v);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sq_capped(longint v);
        longint unsigned a;
        a = mag(v);
        if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
        return a * a;
    endfunction

    function automatic contact_t predict_contact();
        contact_t c;
        longint nx, ny, ex, ey, clx, cly, d, pen;
        longint unsigned d2, r2, r;
        bit ins;
        nx = longint'(circle_pos_x) - longint'(box_pos_x);
        ny = longint'(circle_pos_y) - longint'(box_pos_y);
        ex = (longint'(box_max_x) - longint'(box_min_x)) >>> 1;
        ey = (longint'(box_max_y) - longint'(box_min_y)) >>> 1;
        clx = bound(-ex, ex, nx);
        cly = bound(-ey, ey, ny);
        ins = 0;
        if (clx == nx && cly == ny)
        begin
            ins = 1;
            if (mag(nx) > mag(ny)) clx = (clx > 0) ? ex : -ex;
            else cly = (cly > 0) ? ey : -ey;
        end
        d2 = sq_capped(nx - clx) + sq_capped(ny - cly);
        r = 64'(circle_radius);
        r2 = r * r;
        c = '{default: '0};
        if (d2 > r2 && !ins) return c;
        d = floor_root(d2);
        pen = sat_to(longint'(r) - d, PEN_WIDTH);
        c.hit = 1'b1;
        c.in_box = ins;
        c.nx = NORMAL_WIDTH'(sat_to(ins ? -nx : nx, NORMAL_WIDTH));
        c.ny = NORMAL_WIDTH'(sat_to(ins ? -ny : ny, NORMAL_WIDTH));
        c.pen = PEN_WIDTH'(pen);
        return c;
    endfunction

    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && start && !busy)
            pending_contacts.push_back(predict_contact());
        if (rst_n && done)
        begin
            if (pending_contacts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end
            else
            begin
                e = pending_contacts.pop_front();
                if (hit !== e.hit || center_inside !== e.in_box || normal_x !== e.nx
                    || normal_y !== e.ny || penetration !== e.pen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %b %b %h %h %h got %b %b %h %h %h",
                                 e.hit, e.in_box, e.nx, e.ny, e.pen, hit, center_inside,
                                 normal_x, normal_y, penetration);
                end
            end
        end
    end

    task automatic send_word(input int bpx, bpy, mnx, mny, mxx, mxy, cpx, cpy,
                             input int rad);
        while (!quiet_sender && $urandom_range(99) < 10)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        box_pos_x <= CW'(bpx); box_pos_y <= CW'(bpy);
        box_min_x <= CW'(mnx); box_min_y <= CW'(mny);
        box_max_x <= CW'(mxx); box_max_y <= CW'(mxy);
        circle_pos_x <= CW'(cpx); circle_pos_y <= CW'(cpy);
        circle_radius <= (CW-1)'(rad);
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_contacts.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed();
        logic [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_word(0, 0, -2560, -2560, 2560, 2560, 5000, 0, 3000);
        send_word(0, 0, -2560, -2560, 2560, 2560, 9000, 9000, 100);
        send_word(0, 0, -2560, -2560, 2560, 2560, 100, 50, 10);
        send_word(0, 0, -2560, -2560, 2560, 2560, 50, 100, 10);
        send_word(0, 0, -2560, -2560, 2560, 2560, 70, -70, 10);
        send_word(0, 0, -2560, -2560, 2560, 2560, 0, 0, 0);
        send_word(0, 0, -2561, -2561, 2560, 2560, -100, -20, 5);
        send_word(0, 0, 2560, 2560, -2560, -2560, 100, 100, 500);
        send_word(0, 0, 2561, 2560, -2560, -2561, 0, 0, 0);
        send_word(mn, mn, mn, mn, mx, mx, mx, mx, {(CW-1){1'b1}});
        send_word(mx, mx, mx, mx, mn, mn, mn, mn, {(CW-1){1'b1}});
        send_word(mx, mn, mn, mn, mx, mx, mn, mx, 0);
        send_word(mn, mx, mx, mx, mn, mn, mx, mn, {(CW-1){1'b1}});
        send_word(0, 0, -2560, -2560, 2560, 2560, 3072, 0, 512);
        send_word(mn, 0, 0, 0, 0, 0, mx, 0, {(CW-1){1'b1}});
        send_word(0, 0, mn, mn, mx, mx, 0, 0, 0);
    endtask

    task automatic test_random_scenes(input int count);
        int i, hx, hy, sp;
        int bx, by;
        for (i = 0; i < count; i++)
        begin
            quiet_sender = (i >= count / 3 && i < count / 2);
            if ($urandom_range(9) < 2)
                send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
            else
            begin
                sp = $urandom_range(3) == 0 ? 22 : 14;
                bx = $signed($urandom_range((1 << sp) - 1)) - (1 << (sp - 1));
                by = $signed($urandom_range((1 << sp) - 1)) - (1 << (sp - 1));
                hx = $urandom_range((1 << (sp - 2)));
                hy = $urandom_range((1 << (sp - 2)));
                send_word(bx, by, bx - hx, by - hy, bx + hx + $urandom_range(1),
                          by + hy + $urandom_range(1),
                          bx + $signed($urandom_range(4 * hx + 64)) - 2 * hx - 32,
                          by + $signed($urandom_range(4 * hy + 64)) - 2 * hy - 32,
                          $urandom_range(2 * (hx + hy) + 16));
            end
        end
        quiet_sender = 0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        drain_results();
        test_random_scenes(400);
        drain_results();
        test_random_scenes(400);
        drain_results();
        repeat (LATENCY + 5) @(negedge clk);
        if (mismatches == 0 && pending_contacts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
